>>> hdl/ppgf_pkg.sv
`default_nettype none

package ppgf_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_REGS    = 6;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_PLANE_A      = 3'd0,
        REG_PLANE_B      = 3'd1,
        REG_PLANE_C      = 3'd2,
        REG_PLANE_OFFSET = 3'd3,
        REG_GAP_LIMIT    = 3'd4,
        REG_COLOR_CLASS  = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        COL_RED    = 3'd0,
        COL_YELLOW = 3'd1,
        COL_GREEN  = 3'd2,
        COL_BLUE   = 3'd3,
        COL_BROWN  = 3'd4,
        COL_ORANGE = 3'd5,
        COL_PURPLE = 3'd6
    } t_color;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_SCALE,
        S_DIV,
        S_SAT,
        S_GAP,
        S_DONE
    } t_state;

    // class colour as {red, green, blue}
    function automatic logic [23:0] class_color(input logic [2:0] code);
        logic [23:0] rgb;
        case (code)
            COL_RED:    rgb = {8'd255, 8'd0,   8'd0};
            COL_YELLOW: rgb = {8'd255, 8'd255, 8'd0};
            COL_GREEN:  rgb = {8'd0,   8'd255, 8'd0};
            COL_BLUE:   rgb = {8'd0,   8'd0,   8'd255};
            COL_BROWN:  rgb = {8'd72,  8'd60,  8'd50};
            COL_ORANGE: rgb = {8'd255, 8'd165, 8'd0};
            COL_PURPLE: rgb = {8'd102, 8'd51,  8'd153};
            default:    rgb = 24'd0;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ppgf_queue.sv
`default_nettype none

module ppgf_queue #(
    parameter int W = 98
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

`default_nettype wire

>>> hdl/ppgf_front.sv
`default_nettype none

module ppgf_front #(
    parameter int CW = ppgf_pkg::COORD_WIDTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tvalid,
    output logic                 o_tready,
    input  wire logic [3*CW-1:0] i_point,
    input  wire logic            i_tlast,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output logic [3*CW+1:0]      o_push_data   // {first, last, z, y, x}
);

    // set while the next point opens a batch
    logic r_first;

    assign o_tready    = ~i_q_full;
    assign o_push      = i_tvalid & ~i_q_full;
    assign o_push_data = {r_first, i_tlast, i_point};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_push) begin
            r_first <= i_tlast;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ppgf_back.sv
`default_nettype none

module ppgf_back #(
    parameter int CW   = ppgf_pkg::COORD_WIDTH,
    parameter int FRAC = ppgf_pkg::FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic signed [CW-1:0] i_plane_a,
    input  wire logic signed [CW-1:0] i_plane_b,
    input  wire logic signed [CW-1:0] i_plane_c,
    input  wire logic signed [CW-1:0] i_plane_offset,
    input  wire logic [CW-2:0]        i_gap_limit,
    input  wire logic [2:0]           i_color_class,
    input  wire logic                 i_q_valid,
    input  wire logic [3*CW+1:0]      i_q_data,
    output logic                      o_q_pop,
    output logic                      o_tvalid,
    input  wire logic                 i_tready,
    output logic [CW-1:0]             o_proj_x,
    output logic [CW-1:0]             o_proj_y,
    output logic [CW-1:0]             o_proj_z,
    output logic [7:0]                o_color_red,
    output logic [7:0]                o_color_green,
    output logic [7:0]                o_color_blue,
    output logic                      o_kept,
    output logic                      o_last
);

    localparam int MW   = CW + 1;
    localparam int PW   = 3 * CW;
    localparam int NUMW = 2 * CW + 2;
    localparam int NNW  = 2 * CW;
    localparam int DSW  = 2 * MW;
    localparam int VW   = PW + 2;
    localparam int CNTW = $clog2(PW + 1);

    localparam logic signed [VW-1:0] SAT_MAX = VW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [VW-1:0] SAT_MIN = $signed({{(VW-CW){1'b1}}, {(CW){1'b0}}})
                                               + SAT_MAX + VW'(1);

    ppgf_pkg::t_state r_state, n_state;

    logic [2:0]             r_step;
    logic [1:0]             r_coord;
    logic [CNTW-1:0]        r_cnt;
    logic signed [CW-1:0]   r_x, r_y, r_z;
    logic                   r_last, r_first;
    logic signed [NUMW-1:0] r_num;
    logic [NNW-1:0]         r_nn;
    logic signed [DSW-1:0]  r_prod;
    logic [PW-1:0]          r_acc, r_mcand, r_div;
    logic [CW-1:0]          r_mplier;
    logic [NNW-1:0]         r_rem;
    logic                   r_neg;
    logic signed [CW-1:0]   r_proj [3];
    logic signed [CW-1:0]   r_prev [3];
    logic [DSW-1:0]         r_dist;
    logic                   r_kept;
    logic                   r_ovalid;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [DSW-1:0]  mul_p;
    logic signed [CW-1:0]   sel_n, sel_p;
    logic signed [NUMW-1:0] num_mag;
    logic [CW-1:0]          n_mag;
    logic [PW-1:0]          acc_next;
    logic [NNW:0]           rem_sh;
    logic                   rem_ge;
    logic signed [VW-1:0]   q_s, v_s;
    logic signed [CW-1:0]   v_sat;
    logic                   load_out;
    logic                   scale_end, div_end;

    always_comb begin
        case (r_coord)
            2'd0:    begin sel_n = i_plane_a; sel_p = r_x; end
            2'd1:    begin sel_n = i_plane_b; sel_p = r_y; end
            default: begin sel_n = i_plane_c; sel_p = r_z; end
        endcase
    end

    // one shared multiplier for the dot product, the norm and the gap test
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ppgf_pkg::S_MUL) begin
            case (r_step)
                3'd0:    begin mul_a = MW'(i_plane_a); mul_b = MW'(r_x); end
                3'd1:    begin mul_a = MW'(i_plane_b); mul_b = MW'(r_y); end
                3'd2:    begin mul_a = MW'(i_plane_c); mul_b = MW'(r_z); end
                3'd3:    begin mul_a = MW'(i_plane_a); mul_b = MW'(i_plane_a); end
                3'd4:    begin mul_a = MW'(i_plane_b); mul_b = MW'(i_plane_b); end
                3'd5:    begin mul_a = MW'(i_plane_c); mul_b = MW'(i_plane_c); end
                default: ;
            endcase
        end else if (r_state == ppgf_pkg::S_GAP) begin
            case (r_step)
                3'd0: begin
                    mul_a = MW'(r_proj[0]) - MW'(r_prev[0]);
                    mul_b = mul_a;
                end
                3'd1: begin
                    mul_a = MW'(r_proj[1]) - MW'(r_prev[1]);
                    mul_b = mul_a;
                end
                3'd2: begin
                    mul_a = MW'(r_proj[2]) - MW'(r_prev[2]);
                    mul_b = mul_a;
                end
                3'd3: begin
                    mul_a = $signed({2'b00, i_gap_limit});
                    mul_b = mul_a;
                end
                default: ;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    assign num_mag  = r_num[NUMW-1] ? -r_num : r_num;
    assign n_mag    = sel_n[CW-1] ? $unsigned(-sel_n) : $unsigned(sel_n);
    assign acc_next = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign rem_sh   = {r_rem, r_div[PW-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_nn};
    assign q_s      = $signed({2'b00, r_div});
    assign v_s      = VW'(sel_p) - (r_neg ? -q_s : q_s);

    always_comb begin
        if (v_s > SAT_MAX) begin
            v_sat = {1'b0, {(CW-1){1'b1}}};
        end else if (v_s < SAT_MIN) begin
            v_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            v_sat = v_s[CW-1:0];
        end
    end

    assign scale_end = (r_cnt == CNTW'(CW - 1));
    assign div_end   = (r_cnt == CNTW'(PW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppgf_pkg::S_IDLE:  if (i_q_valid) n_state = ppgf_pkg::S_MUL;
            ppgf_pkg::S_MUL:   if (r_step == 3'd6) n_state = ppgf_pkg::S_INIT;
            ppgf_pkg::S_INIT:  n_state = (r_nn == '0) ? ppgf_pkg::S_SAT : ppgf_pkg::S_SCALE;
            ppgf_pkg::S_SCALE: if (scale_end) n_state = ppgf_pkg::S_DIV;
            ppgf_pkg::S_DIV:   if (div_end) n_state = ppgf_pkg::S_SAT;
            ppgf_pkg::S_SAT:   n_state = (r_coord == 2'd2) ? ppgf_pkg::S_GAP
                                                           : ppgf_pkg::S_INIT;
            ppgf_pkg::S_GAP:   if (r_first || r_step == 3'd4) n_state = ppgf_pkg::S_DONE;
            ppgf_pkg::S_DONE:  if (load_out) n_state = ppgf_pkg::S_IDLE;
            default:           n_state = ppgf_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ppgf_pkg::S_IDLE: o_q_pop  = i_q_valid;
            ppgf_pkg::S_DONE: load_out = ~r_ovalid | i_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppgf_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_prev   <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ppgf_pkg::S_GAP) begin
                if (r_first || (r_step == 3'd4 && r_dist < $unsigned(r_prod))) begin
                    r_prev <= r_proj;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ppgf_pkg::S_IDLE: begin
                r_x     <= $signed(i_q_data[CW-1:0]);
                r_y     <= $signed(i_q_data[2*CW-1:CW]);
                r_z     <= $signed(i_q_data[3*CW-1:2*CW]);
                r_last  <= i_q_data[3*CW];
                r_first <= i_q_data[3*CW+1];
                r_num   <= NUMW'(i_plane_offset) <<< FRAC;
                r_nn    <= '0;
                r_step  <= 3'd0;
                r_coord <= 2'd0;
            end
            ppgf_pkg::S_MUL: begin
                r_prod <= mul_p;
                if (r_step >= 3'd1 && r_step <= 3'd3) begin
                    r_num <= r_num + r_prod;
                end else if (r_step >= 3'd4) begin
                    r_nn <= r_nn + r_prod[NNW-1:0];
                end
                r_step <= r_step + 3'd1;
            end
            ppgf_pkg::S_INIT: begin
                r_acc    <= '0;
                r_mcand  <= PW'($unsigned(num_mag));
                r_mplier <= n_mag;
                r_neg    <= (r_nn != '0) & (r_num[NUMW-1] ^ sel_n[CW-1]);
                r_div    <= '0;
                r_cnt    <= '0;
            end
            ppgf_pkg::S_SCALE: begin
                // shift-add: one multiplier bit per cycle
                r_acc    <= acc_next;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + CNTW'(1);
                if (scale_end) begin
                    r_div <= acc_next;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            ppgf_pkg::S_DIV: begin
                // restoring division, quotient shifts into the dividend
                r_rem <= rem_ge ? NNW'(rem_sh - {1'b0, r_nn}) : rem_sh[NNW-1:0];
                r_div <= {r_div[PW-2:0], rem_ge};
                r_cnt <= r_cnt + CNTW'(1);
            end
            ppgf_pkg::S_SAT: begin
                r_proj[r_coord] <= v_sat;
                r_coord         <= r_coord + 2'd1;
                r_step          <= 3'd0;
                r_dist          <= '0;
            end
            ppgf_pkg::S_GAP: begin
                r_prod <= mul_p;
                r_step <= r_step + 3'd1;
                if (r_first) begin
                    r_kept <= 1'b0;
                end else if (r_step >= 3'd1 && r_step <= 3'd3) begin
                    r_dist <= r_dist + $unsigned(r_prod);
                end else if (r_step == 3'd4) begin
                    r_kept <= r_dist < $unsigned(r_prod);
                end
            end
            default: ;
        endcase
    end

    logic [23:0] r_out_rgb;
    logic [CW-1:0] r_ox, r_oy, r_oz;
    logic r_okept, r_olast;

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ox      <= r_proj[0];
            r_oy      <= r_proj[1];
            r_oz      <= r_proj[2];
            r_out_rgb <= ppgf_pkg::class_color(i_color_class);
            r_okept   <= r_kept;
            r_olast   <= r_last;
        end
    end

    assign o_tvalid      = r_ovalid;
    assign o_proj_x      = r_ox;
    assign o_proj_y      = r_oy;
    assign o_proj_z      = r_oz;
    assign o_color_red   = r_out_rgb[23:16];
    assign o_color_green = r_out_rgb[15:8];
    assign o_color_blue  = r_out_rgb[7:0];
    assign o_kept        = r_okept;
    assign o_last        = r_olast;

    a_scale_nonzero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ppgf_pkg::S_SCALE |-> r_nn != '0)
        else $error("scaling started with a zero normal");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ppgf_pkg::S_DONE)
        else $error("result raised outside the done state");

    a_seed_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppgf_pkg::S_DONE && r_first) |-> !r_kept)
        else $error("first point of a batch marked kept");

endmodule

`default_nettype wire

>>> hdl/plane_projection_gap_filter.sv
`default_nettype none

// Channel   Dir  Handshake                  Contents
// s_axis    in   s_axis_tvalid/tready       tdata {z,y,x}, tlast batch_last
// m_axis    out  m_axis_tvalid/tready       tdata {blue,green,red,z,y,x}, tuser kept,
//                                           tlast out_last
// apb       in   psel/penable/pwrite        six registers at 4*i (8*i above 32 bits)
//
// The back end handles one point at a time: the bit-serial scale and the restoring
// divider run once per coordinate; a zero normal skips both. A two-entry queue lets
// the input take points while the back end works, and the output register holds a
// result until it is taken. Reset is synchronous, active low; no clearing pass.
module plane_projection_gap_filter #(
    parameter int COORD_WIDTH = ppgf_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = ppgf_pkg::FRAC_BITS,
    localparam int CW  = COORD_WIDTH,
    localparam int TIW = ((3 * CW + 7) / 8) * 8,
    localparam int TOW = ((3 * CW + 24 + 7) / 8) * 8,
    localparam int DW  = (CW > 32) ? 64 : 32,
    localparam int SH  = $clog2(DW / 8),
    localparam int AW  = $clog2(ppgf_pkg::NUM_REGS * (DW / 8))
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TIW-1:0]         s_axis_tdata,   // pt_x, pt_y, pt_z
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TOW-1:0]              m_axis_tdata,   // proj_x, proj_y, proj_z,
                                                        // color_red, green, blue
    output logic                        m_axis_tuser,   // kept
    output logic                        m_axis_tlast,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [AW-1:0]          paddr,
    input  wire logic [DW-1:0]          pwdata,
    output logic [DW-1:0]               prdata,
    output logic                        pready
);

    localparam int IW  = AW - SH;
    localparam logic [CW-2:0] GAP_RESET = (CW-1)'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    logic signed [CW-1:0] r_plane_a, r_plane_b, r_plane_c, r_plane_offset;
    logic [CW-2:0]        r_gap_limit;
    logic [2:0]           r_color_class;
    logic [IW-1:0]        reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AW-1:SH];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_a      <= '0;
            r_plane_b      <= '0;
            r_plane_c      <= CW'(64'd1 << FRAC_BITS);
            r_plane_offset <= '0;
            r_gap_limit    <= GAP_RESET;
            r_color_class  <= 3'd0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                IW'(ppgf_pkg::REG_PLANE_A):      r_plane_a      <= pwdata[CW-1:0];
                IW'(ppgf_pkg::REG_PLANE_B):      r_plane_b      <= pwdata[CW-1:0];
                IW'(ppgf_pkg::REG_PLANE_C):      r_plane_c      <= pwdata[CW-1:0];
                IW'(ppgf_pkg::REG_PLANE_OFFSET): r_plane_offset <= pwdata[CW-1:0];
                IW'(ppgf_pkg::REG_GAP_LIMIT):    r_gap_limit    <= pwdata[CW-2:0];
                IW'(ppgf_pkg::REG_COLOR_CLASS):  r_color_class  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            IW'(ppgf_pkg::REG_PLANE_A):      prdata = DW'($unsigned(r_plane_a));
            IW'(ppgf_pkg::REG_PLANE_B):      prdata = DW'($unsigned(r_plane_b));
            IW'(ppgf_pkg::REG_PLANE_C):      prdata = DW'($unsigned(r_plane_c));
            IW'(ppgf_pkg::REG_PLANE_OFFSET): prdata = DW'($unsigned(r_plane_offset));
            IW'(ppgf_pkg::REG_GAP_LIMIT):    prdata = DW'(r_gap_limit);
            IW'(ppgf_pkg::REG_COLOR_CLASS):  prdata = DW'(r_color_class);
            default:                         prdata = '0;
        endcase
    end

    logic               q_push, q_pop, q_full, q_valid;
    logic [3*CW+1:0]    q_wdata, q_rdata;

    ppgf_front #(.CW(CW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_point     (s_axis_tdata[3*CW-1:0]),
        .i_tlast     (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_wdata)
    );

    ppgf_queue #(.W(3 * CW + 2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    logic [CW-1:0] proj_x, proj_y, proj_z;
    logic [7:0]    col_r, col_g, col_b;

    ppgf_back #(.CW(CW), .FRAC(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_plane_a      (r_plane_a),
        .i_plane_b      (r_plane_b),
        .i_plane_c      (r_plane_c),
        .i_plane_offset (r_plane_offset),
        .i_gap_limit    (r_gap_limit),
        .i_color_class  (r_color_class),
        .i_q_valid      (q_valid),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .o_tvalid       (m_axis_tvalid),
        .i_tready       (m_axis_tready),
        .o_proj_x       (proj_x),
        .o_proj_y       (proj_y),
        .o_proj_z       (proj_z),
        .o_color_red    (col_r),
        .o_color_green  (col_g),
        .o_color_blue   (col_b),
        .o_kept         (m_axis_tuser),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = TOW'({col_b, col_g, col_r, proj_z, proj_y, proj_x});

endmodule

`default_nettype wire

>>> dv/plane_projection_gap_filter_tb.sv
`default_nettype none

module plane_projection_gap_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = ppgf_pkg::COORD_WIDTH;
    localparam int IDLE_MAX  = 20000;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN     = 500;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic                 last;
    } t_point;

    typedef struct {
        logic signed [CW-1:0] px, py, pz;
        logic [7:0]           red, green, blue;
        logic                 kept, last;
    } t_proj;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [95:0]   s_data = '0;     // pt_x, pt_y, pt_z
    logic          s_last = 1'b0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [119:0]  m_data;          // proj_x, proj_y, proj_z, red, green, blue
    logic          m_user;          // kept
    logic          m_last;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    plane_projection_gap_filter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tlast(s_last),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow configuration and filter state
    logic signed [CW-1:0] nrm_a, nrm_b, nrm_c, pl_d;
    logic [CW-2:0]        gap_lim;
    logic [2:0]           color_code;
    logic                 seed_next;
    logic signed [CW-1:0] last_x, last_y, last_z;

    t_point pend_q[$];
    t_proj  proj_q[$];
    int     n_sent, n_recv, n_kept, n_err;
    int     tx_gap, rx_gap, rx_long;
    logic   long_done;
    int     idle_cnt;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [23:0] rgb_of(input logic [2:0] code);
        case (code)
            ppgf_pkg::COL_RED:    return {8'd255, 8'd0, 8'd0};
            ppgf_pkg::COL_YELLOW: return {8'd255, 8'd255, 8'd0};
            ppgf_pkg::COL_GREEN:  return {8'd0, 8'd255, 8'd0};
            ppgf_pkg::COL_BLUE:   return {8'd0, 8'd0, 8'd255};
            ppgf_pkg::COL_BROWN:  return {8'd72, 8'd60, 8'd50};
            ppgf_pkg::COL_ORANGE: return {8'd255, 8'd165, 8'd0};
            ppgf_pkg::COL_PURPLE: return {8'd102, 8'd51, 8'd153};
            default:              return 24'd0;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] onto_plane(input t_wide p, ni, num, nn);
        t_wide v;
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -(t_wide'(1) <<< (CW - 1));
        v = p;
        if (nn != 0) v = p - (num * ni) / nn;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    task automatic project_point(input t_point pt);
        t_wide x, y, z, a, b, c, d, g, num, nn, dx, dy, dz;
        t_proj e;
        logic [23:0] rgb;
        x = pt.x; y = pt.y; z = pt.z;
        a = nrm_a; b = nrm_b; c = nrm_c; d = pl_d;
        g = {1'b0, gap_lim};
        num = a * x + b * y + c * z + (d <<< ppgf_pkg::FRAC_BITS);
        nn = a * a + b * b + c * c;
        e.px = onto_plane(x, a, num, nn);
        e.py = onto_plane(y, b, num, nn);
        e.pz = onto_plane(z, c, num, nn);
        e.kept = 1'b0;
        if (seed_next) begin
            seed_next = 1'b0;
            last_x = e.px; last_y = e.py; last_z = e.pz;
        end else begin
            dx = t_wide'(e.px) - t_wide'(last_x);
            dy = t_wide'(e.py) - t_wide'(last_y);
            dz = t_wide'(e.pz) - t_wide'(last_z);
            if (dx * dx + dy * dy + dz * dz < g * g) begin
                e.kept = 1'b1;
                last_x = e.px; last_y = e.py; last_z = e.pz;
            end
        end
        if (pt.last) seed_next = 1'b1;
        rgb = rgb_of(color_code);
        {e.red, e.green, e.blue} = rgb;
        e.last = pt.last;
        proj_q = {proj_q, e};
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_point it;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                it.x = s_data[31:0]; it.y = s_data[63:32]; it.z = s_data[95:64];
                it.last = s_last;
                project_point(it);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    it = pend_q.pop_front();
                    s_data  <= {it.z, it.y, it.x};
                    s_last  <= it.last;
                    s_valid <= 1'b1;
                    tx_gap  <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin
        t_proj e;
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            rx_gap    <= 0;
            rx_long   <= 0;
            long_done <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_recv++;
                if (proj_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_err++;
                end else begin
                    e = proj_q.pop_front();
                    if (m_user) n_kept++;
                    if (m_data[31:0] !== e.px) begin
                        $error("proj_x exp %h got %h", e.px, m_data[31:0]); n_err++;
                    end
                    if (m_data[63:32] !== e.py) begin
                        $error("proj_y exp %h got %h", e.py, m_data[63:32]); n_err++;
                    end
                    if (m_data[95:64] !== e.pz) begin
                        $error("proj_z exp %h got %h", e.pz, m_data[95:64]); n_err++;
                    end
                    if (m_data[103:96] !== e.red) begin
                        $error("color_red exp %0d got %0d", e.red, m_data[103:96]); n_err++;
                    end
                    if (m_data[111:104] !== e.green) begin
                        $error("color_green exp %0d got %0d", e.green, m_data[111:104]);
                        n_err++;
                    end
                    if (m_data[119:112] !== e.blue) begin
                        $error("color_blue exp %0d got %0d", e.blue, m_data[119:112]);
                        n_err++;
                    end
                    if (m_user !== e.kept) begin
                        $error("kept exp %0b got %0b", e.kept, m_user); n_err++;
                    end
                    if (m_last !== e.last) begin
                        $error("out_last exp %0b got %0b", e.last, m_last); n_err++;
                    end
                end
            end
            // hold off once for a long stretch so the input queue backs up
            if (rx_long > 0) begin
                rx_long <= rx_long - 1;
                m_ready <= 1'b0;
            end else if (n_recv == 100 && !long_done) begin
                long_done <= 1'b1;
                rx_long   <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap  <= pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_MAX) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    task automatic reg_write(input ppgf_pkg::t_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(4 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ppgf_pkg::REG_PLANE_A:      nrm_a = val;
            ppgf_pkg::REG_PLANE_B:      nrm_b = val;
            ppgf_pkg::REG_PLANE_C:      nrm_c = val;
            ppgf_pkg::REG_PLANE_OFFSET: pl_d = val;
            ppgf_pkg::REG_GAP_LIMIT:    gap_lim = val[CW-2:0];
            ppgf_pkg::REG_COLOR_CLASS:  color_code = val[2:0];
            default: ;
        endcase
    endtask

    task automatic push_pt(input logic [31:0] x, y, z, input logic last);
        t_point p;
        p.x = x; p.y = y; p.z = z; p.last = last;
        pend_q = {pend_q, p};
    endtask

    task automatic drain();
        @(posedge i_clk); #1;
        while (pend_q.size() > 0 || s_valid || proj_q.size() > 0) begin
            @(posedge i_clk); #1;
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] base, input int spread);
        return base + 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // well-formed batches of nearby points, with some noise mixed in
    task automatic queue_batches(input int count);
        logic [31:0] bx, by, bz;
        int len, spread;
        while (count > 0) begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            spread = (gap_lim > 0 && gap_lim < 32'h0100_0000) ? int'(gap_lim) : 6554;
            bx = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            by = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            bz = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            for (int i = 0; i < len && count > 0; i++) begin
                if ($urandom_range(0, 7) == 0)
                    push_pt($urandom(), $urandom(), $urandom(), i == len - 1);
                else
                    push_pt(near(bx, spread), near(by, spread), near(bz, spread),
                            i == len - 1);
                count--;
            end
        end
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endfunction

    initial begin
        nrm_a = '0; nrm_b = '0; nrm_c = 32'h0001_0000; pl_d = '0;
        gap_lim = 31'd6554; color_code = ppgf_pkg::COL_RED;
        seed_next = 1'b1; last_x = '0; last_y = '0; last_z = '0;
        n_sent = 0; n_recv = 0; n_kept = 0; n_err = 0; idle_cnt = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: lone point, coordinate extremes, near and far steps
        push_pt(32'h0, 32'h0, 32'h0, 1'b1);
        push_pt(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        push_pt(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        push_pt(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 1'b0);
        push_pt(32'h0001_0800, 32'h0002_0000, 32'hfff0_0000, 1'b0);
        push_pt(32'h0009_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);
        push_pt(32'h0001_1000, 32'h0002_0400, 32'h1234_5678, 1'b1);
        push_pt(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b1);
        drain();

        // extreme plane: saturation of the projection, widest gap, purple
        reg_write(ppgf_pkg::REG_PLANE_A, 32'h7fff_ffff);
        reg_write(ppgf_pkg::REG_PLANE_B, 32'h8000_0000);
        reg_write(ppgf_pkg::REG_PLANE_C, 32'h8000_0000);
        reg_write(ppgf_pkg::REG_PLANE_OFFSET, 32'h7fff_ffff);
        reg_write(ppgf_pkg::REG_GAP_LIMIT, 32'h7fff_ffff);
        reg_write(ppgf_pkg::REG_COLOR_CLASS, ppgf_pkg::COL_PURPLE);
        push_pt(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        push_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_pt(32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        push_pt(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f, 1'b1);
        drain();

        // zero normal passes points through; unused class code gives black
        reg_write(ppgf_pkg::REG_PLANE_A, 32'h0);
        reg_write(ppgf_pkg::REG_PLANE_B, 32'h0);
        reg_write(ppgf_pkg::REG_PLANE_C, 32'h0);
        reg_write(ppgf_pkg::REG_PLANE_OFFSET, 32'h8000_0000);
        reg_write(ppgf_pkg::REG_GAP_LIMIT, 32'h0);
        reg_write(ppgf_pkg::REG_COLOR_CLASS, 32'd7);
        push_pt(32'h7fff_ffff, 32'h8000_0000, 32'h0000_1234, 1'b0);
        push_pt(32'h7fff_ffff, 32'h8000_0000, 32'h0000_1234, 1'b0);
        push_pt(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 1'b1);
        drain();

        // random planes, gaps and colors
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ppgf_pkg::REG_PLANE_A, rand_coef());
            reg_write(ppgf_pkg::REG_PLANE_B, rand_coef());
            reg_write(ppgf_pkg::REG_PLANE_C, rand_coef());
            reg_write(ppgf_pkg::REG_PLANE_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom() :
                      32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000));
            case ($urandom_range(0, 7))
                0:       reg_write(ppgf_pkg::REG_GAP_LIMIT, 32'h0);
                1:       reg_write(ppgf_pkg::REG_GAP_LIMIT, 32'h7fff_ffff);
                default: reg_write(ppgf_pkg::REG_GAP_LIMIT, $urandom_range(1000, 200000));
            endcase
            reg_write(ppgf_pkg::REG_COLOR_CLASS, $urandom_range(0, 7));
            queue_batches(110);
            drain();
        end

        $display("%0d points sent, %0d results checked, %0d kept, over 11 settings",
                 n_sent, n_recv, n_kept);
        if (n_err == 0 && proj_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/ppgf_pkg.sv
hdl/ppgf_queue.sv
hdl/ppgf_front.sv
hdl/ppgf_back.sv
hdl/plane_projection_gap_filter.sv
dv/plane_projection_gap_filter_tb.sv
